### rtl/ppsw_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise-polynomial shape weight package
// Shared constants, segment coefficient tables and arithmetic helpers.
// ----------------------------------------------------------------------------
package ppsw_pkg;

  // Default number of fraction bits on the coordinate inputs.
  localparam int PPSW_COORD_FRAC_BITS = 16;

  // Internal coordinate format is Q28; the Horner accumulator holds Q32.
  localparam int INT_FRAC = 28;
  localparam int ACC_W    = 40;
  localparam int COEF_N   = 9;

  // Pipeline depths of the lanes and of the merging stage.
  localparam int LANE_LAT  = 18;
  localparam int MERGE_LAT = 4;

  // Function selector codes.
  localparam logic [1:0] FUNC_W1   = 2'd0;
  localparam logic [1:0] FUNC_W1D  = 2'd1;
  localparam logic [1:0] FUNC_W3D  = 2'd2;

  // Context that travels down a lane next to the accumulator.
  typedef struct packed {
    logic signed [16:0] xh;
    logic [13:0]        xl;
    logic [1:0]         seg;
    logic               deriv;
    logic               ins;
  } ctx_t;

  // Weight coefficients in units of 1/1024, highest power first.
  localparam logic signed [11:0] W1_TAB [4][COEF_N] = '{
    '{  12'sd15,  12'sd120, 12'sd392,  12'sd672, 12'sd560, 12'sd0,  12'sd0,
        12'sd1024, 12'sd1024 },
    '{ -12'sd15,  12'sd120, 12'sd448,  12'sd672, 12'sd700, 12'sd0, -12'sd840,
        12'sd0,    12'sd674 },
    '{ -12'sd15, -12'sd120, 12'sd448, -12'sd672, 12'sd700, 12'sd0, -12'sd840,
        12'sd0,    12'sd674 },
    '{  12'sd15, -12'sd120, 12'sd392, -12'sd672, 12'sd560, 12'sd0,  12'sd0,
       -12'sd1024, 12'sd1024 }
  };

  // Derivative coefficients in units of 1/128, led by a zero so that the
  // degree-seven polynomial runs through the same nine steps.
  localparam logic signed [11:0] W1D_TAB [4][COEF_N] = '{
    '{ 12'sd0,  12'sd15,  12'sd105, 12'sd294,  12'sd420, 12'sd280, 12'sd0,
       12'sd0,     12'sd128 },
    '{ 12'sd0, -12'sd15,  12'sd105, 12'sd336,  12'sd420, 12'sd350, 12'sd0,
      -12'sd210,   12'sd0 },
    '{ 12'sd0, -12'sd15, -12'sd105, 12'sd336, -12'sd420, 12'sd350, 12'sd0,
      -12'sd210,   12'sd0 },
    '{ 12'sd0,  12'sd15, -12'sd105, 12'sd294, -12'sd420, 12'sd280, 12'sd0,
       12'sd0,    -12'sd128 }
  };

  // Coefficient k of a segment, scaled to Q32.
  function automatic logic signed [ACC_W-1:0] lane_coef(input logic deriv,
                                                       input logic [1:0] seg,
                                                       input int k);
    logic signed [ACC_W-1:0] c;
    if (deriv) begin
      c = ACC_W'(W1D_TAB[seg][k]) <<< 25;
    end else begin
      c = ACC_W'(W1_TAB[seg][k]) <<< 22;
    end
    return c;
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/ppsw_lane.sv
// ----------------------------------------------------------------------------
// Shape weight lane
// Evaluates W1 or its derivative at one coordinate by a pipelined Horner
// chain: each of the eight steps takes a multiply stage and an add stage.
// ----------------------------------------------------------------------------
module ppsw_lane
  import ppsw_pkg::*;
#(
  parameter int COORD_FRAC_BITS = PPSW_COORD_FRAC_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  logic               deriv,
  input  logic signed [19:0] coord,
  output logic signed [31:0] weight
);

  localparam int SH = INT_FRAC - COORD_FRAC_BITS;
  localparam logic signed [31:0] EDGE = 32'sd1 <<< (COORD_FRAC_BITS + 1);

  logic signed [31:0] coord_ext;
  logic signed [47:0] xq_wide;
  logic [30:0]        xq;
  ctx_t               ctx0;

  ctx_t                    ctx_r [0:16];
  logic signed [ACC_W-1:0] acc_r [0:8];
  logic signed [56:0]      phi_r [1:8];
  logic signed [54:0]      plo_r [1:8];
  logic signed [31:0]      weight_r;

  // Scale to Q28, test the support and pick the segment.
  always_comb begin
    coord_ext = {{12{coord[19]}}, coord};
    xq_wide   = {{28{coord[19]}}, coord} <<< SH;
    xq        = xq_wide[30:0];
    ctx0.xh    = xq[30:14];
    ctx0.xl    = xq[13:0];
    ctx0.seg   = {~xq[29], xq[28]};
    ctx0.deriv = deriv;
    ctx0.ins   = (coord_ext >= -EDGE) && (coord_ext < EDGE);
  end

  // Leading coefficient.
  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx0;
      acc_r[0] <= lane_coef(ctx0.deriv, ctx0.seg, 0);
    end
  end

  // Horner steps: split product, then floor shift and coefficient add.
  for (genvar k = 1; k < COEF_N; k++) begin : g_step
    logic signed [70:0] sum;
    assign sum = (71'(phi_r[k]) <<< 14) + 71'(plo_r[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[2*k-1] <= ctx_r[2*k-2];
        phi_r[k]     <= acc_r[k-1] * ctx_r[2*k-2].xh;
        plo_r[k]     <= acc_r[k-1] * $signed({1'b0, ctx_r[2*k-2].xl});
        ctx_r[2*k]   <= ctx_r[2*k-1];
        acc_r[k]     <= $signed(sum[67:28])
                        + lane_coef(ctx_r[2*k-1].deriv, ctx_r[2*k-1].seg, k);
      end
    end
  end

  // Q32 to Q30, saturate, and zero outside the support.
  always_ff @(posedge clk) begin
    if (en) begin
      if (ctx_r[16].ins) begin
        weight_r <= sat32(64'($signed(acc_r[8][ACC_W-1:2])));
      end else begin
        weight_r <= '0;
      end
    end
  end

  assign weight = weight_r;

endmodule

### rtl/ppsw_merge.sv
// ----------------------------------------------------------------------------
// Shape weight merging stage
// Forms the three-dimensional product of the lane weights or passes the
// x lane through, according to the function code; an unused code gives zero.
// ----------------------------------------------------------------------------
module ppsw_merge
  import ppsw_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [1:0]         func,
  input  logic signed [31:0] wx,
  input  logic signed [31:0] wy,
  input  logic signed [31:0] wz,
  output logic signed [31:0] result
);

  logic signed [63:0] p1_r, p2_r;
  logic signed [31:0] r1_r, res_r;
  logic signed [31:0] wz1_r, wz2_r, wx1_r, wx2_r, wx3_r;
  logic [1:0]         f1_r, f2_r, f3_r;

  // Two product steps with saturation between them, then selection.
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= wx * wy;
      wz1_r <= wz;
      wx1_r <= wx;
      f1_r  <= func;

      r1_r  <= sat32(p1_r >>> 30);
      wz2_r <= wz1_r;
      wx2_r <= wx1_r;
      f2_r  <= f1_r;

      p2_r  <= r1_r * wz2_r;
      wx3_r <= wx2_r;
      f3_r  <= f2_r;

      case (f3_r)
        FUNC_W1, FUNC_W1D: begin
          res_r <= wx3_r;
        end
        FUNC_W3D: begin
          res_r <= sat32(p2_r >>> 30);
        end
        default: begin
          res_r <= '0;
        end
      endcase
    end
  end

  assign result = res_r;

endmodule

### rtl/piecewise_poly_shape_weight_core.sv
// ----------------------------------------------------------------------------
// Piecewise-polynomial shape weight core
// Eighth-order particle shape weight, its derivative and the 3-D product.
// ----------------------------------------------------------------------------
// The core accepts one transaction per clock while the pipeline is not held.
// Each result passes through the three Horner lanes (eight multiply and add
// steps of two stages each, plus input and saturation stages) and then the
// merging stage that forms the product W1(x)*W1(y)*W1(z). When a finished
// result is held by out_stall the whole pipeline holds and in_stall rises in
// the same cycle.
module piecewise_poly_shape_weight_core
  import ppsw_pkg::*;
#(
  parameter int COORD_FRAC_BITS = PPSW_COORD_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [19:0] in_coord_x,
  input  logic signed [19:0] in_coord_y,
  input  logic signed [19:0] in_coord_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value
);

  localparam int LAT = LANE_LAT + MERGE_LAT;

  logic               adv;
  logic [LAT-1:0]     vld_r;
  logic [1:0]         func_r [0:LANE_LAT-1];
  logic signed [31:0] wx, wy, wz;

  // The pipeline moves unless a finished result is held back.
  assign adv      = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[LAT-1];

  // Valid flags follow each transaction down the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Function code travels beside the lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      func_r[0] <= in_func;
      for (int i = 1; i < LANE_LAT; i++) begin
        func_r[i] <= func_r[i-1];
      end
    end
  end

  // Three lanes, one per coordinate.
  ppsw_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_x (
    .clk(clk), .en(adv), .deriv(in_func == FUNC_W1D), .coord(in_coord_x), .weight(wx)
  );
  ppsw_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_y (
    .clk(clk), .en(adv), .deriv(1'b0), .coord(in_coord_y), .weight(wy)
  );
  ppsw_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_z (
    .clk(clk), .en(adv), .deriv(1'b0), .coord(in_coord_z), .weight(wz)
  );

  ppsw_merge u_merge (
    .clk(clk), .en(adv), .func(func_r[LANE_LAT-1]),
    .wx(wx), .wy(wy), .wz(wz), .result(out_result_value)
  );

  // A held pipeline keeps its valid flags.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid flags moved while the pipeline was held");

  // A result leaves only through a completed transaction.
  a_fell: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without a transaction");

  // The stage before the output fills it when the pipeline moves.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[LAT-2]) |=> out_valid)
    else $error("result lost before the output register");

endmodule
